// ----- design/salc_pkg.sv -----
// shared types and constants for the set associative lru cache model
// no dependencies
package salc_pkg;

  localparam int unsigned AddrW = 32;
  localparam int unsigned CntW  = 32;
  localparam int unsigned RankW = 5;
  localparam logic [RankW-1:0] RankLimit = 5'd31;

  localparam logic [1:0] CfgAssoc    = 2'd0;
  localparam logic [1:0] CfgWrAlloc  = 2'd1;
  localparam logic [1:0] CfgPrefetch = 2'd2;

  localparam logic [1:0] PfNone   = 2'd0;
  localparam logic [1:0] PfAlways = 2'd1;
  localparam logic [1:0] PfOnMiss = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE,
    ST_OUT
  } exec_state_e;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] address;
  } req_t;

endpackage

// ----- design/set_assoc_lru_cache_sim_core.sv -----
// top level of the set associative lru cache model
// depends on salc_pkg, salc_front, salc_back
// After reset the back end clears its line rows, one row of MaxW lines per cycle,
// while the two-entry input queue may already take beats. The back end then handles
// one access at a time: accept, row read, compare, row write and result beat; a
// next-line prefetch adds its own read, compare and write before the result beat. A
// stalled result holds the back end, and the queue then fills and drops s_axis_tready.
// All sizes must be powers of two. Configuration may be written only while no access
// is in flight.
module set_assoc_lru_cache_sim_core #(
  parameter int unsigned CACHE_BYTES = 16384,
  parameter int unsigned LINE_BYTES  = 32,
  parameter int unsigned MAX_WAYS    = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // address
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // hit, hit_count, access_count, pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [2:0]  cfg_data_i
);
  import salc_pkg::*;

  logic [2:0] assoc_q;
  logic       wa_q;
  logic [1:0] pf_q;
  req_t       in_req, req;
  logic       rv, rr;

  assign cfg_ready_o = 1'b1;
  assign in_req = '{mode: s_axis_tuser, address: s_axis_tdata};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      assoc_q <= 3'd1;
      wa_q    <= 1'b1;
      pf_q    <= PfNone;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAssoc:    assoc_q <= cfg_data_i;
        CfgWrAlloc:  wa_q    <= cfg_data_i[0];
        CfgPrefetch: pf_q    <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  salc_front u_front (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
    .in_req_i(in_req), .req_valid_o(rv), .req_ready_i(rr), .req_o(req)
  );

  salc_back #(.CACHE_BYTES(CACHE_BYTES), .LINE_BYTES(LINE_BYTES),
              .MAX_WAYS(MAX_WAYS)) u_back (
    .clk_i, .rst_ni,
    .assoc_log2_i(assoc_q), .write_allocate_i(wa_q), .prefetch_mode_i(pf_q),
    .req_valid_i(rv), .req_ready_o(rr), .req_i(req),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

endmodule

// ----- design/salc_front.sv -----
// front end: accepts accesses into a two entry request queue
// depends on salc_pkg
module salc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  salc_pkg::req_t in_req_i,
  output logic          req_valid_o,
  input  logic          req_ready_i,
  output salc_pkg::req_t req_o
);
  import salc_pkg::*;

  req_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign s_axis_tready = (cnt_q != 2'd2);
  assign push          = s_axis_tvalid && s_axis_tready;
  assign req_valid_o   = (cnt_q != 2'd0);
  assign pop           = req_valid_o && req_ready_i;
  assign req_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_req_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- design/salc_back.sv -----
// back end: set lookup, lru update, fill, prefetch and counters
// depends on salc_pkg
module salc_back #(
  parameter int unsigned CACHE_BYTES = 16384,
  parameter int unsigned LINE_BYTES  = 32,
  parameter int unsigned MAX_WAYS    = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [2:0]     assoc_log2_i,
  input  logic           write_allocate_i,
  input  logic [1:0]     prefetch_mode_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  salc_pkg::req_t req_i,
  output logic           m_axis_tvalid,
  input  logic           m_axis_tready,
  output logic [71:0]    m_axis_tdata
);
  import salc_pkg::*;

  localparam int unsigned NumLines = CACHE_BYTES / LINE_BYTES;
  localparam int unsigned IdxW     = $clog2(NumLines);
  localparam int unsigned OffW     = $clog2(LINE_BYTES);
  localparam int unsigned BlkW     = AddrW - OffW;
  localparam int unsigned MaxW     = (MAX_WAYS < NumLines) ? MAX_WAYS : NumLines;
  localparam int unsigned LaneW    = $clog2(MaxW);
  // a row holds MaxW lines, so every set of any way count lies in one row
  localparam int unsigned Rows     = NumLines / MaxW;
  localparam int unsigned RowW     = (Rows > 1) ? $clog2(Rows) : 1;

  typedef logic [MaxW-1:0][BlkW-1:0]  tag_row_t;
  typedef logic [MaxW-1:0][RankW-1:0] rank_row_t;

  tag_row_t         tag_mem   [Rows];
  logic [MaxW-1:0]  valid_mem [Rows];
  rank_row_t        rank_mem  [Rows];

  exec_state_e      state_q, state_d;
  logic [RowW-1:0]  clr_q;
  logic [BlkW-1:0]  blk_q;
  logic [2:0]       wl_q;
  logic             alloc_q, dmd_q;
  tag_row_t         rd_tag_q;
  logic [MaxW-1:0]  rd_valid_q;
  rank_row_t        rd_rank_q;
  logic             found_q, inv_found_q;
  logic [LaneW-1:0] hit_lane_q, inv_lane_q, vic_lane_q;
  logic             hit_q;
  logic [CntW-1:0]  hits_q, acc_q;

  logic [IdxW-1:0]  base;
  logic [RowW-1:0]  row;
  logic [LaneW-1:0] off;
  logic [MaxW-1:0]  in_set, hit_vec, inv_vec, vic_vec;
  logic             any_hit, any_inv;
  logic [LaneW-1:0] hit_lane, inv_lane, vic_lane, tgt_lane;
  logic [RankW-1:0] prev_rank;
  tag_row_t         wr_tag;
  logic [MaxW-1:0]  wr_valid;
  rank_row_t        wr_rank;
  logic             pf_go;
  logic             rd_en, mem_we, mem_clr;

  // base line of the set is (block * ways) mod lines
  assign base = blk_q[IdxW-1:0] << wl_q;
  assign row  = RowW'(base >> LaneW);
  assign off  = base[LaneW-1:0];

  assign m_axis_tdata = {7'd0, acc_q, hits_q, hit_q};

  assign pf_go = dmd_q && (prefetch_mode_i == PfAlways ||
                           (prefetch_mode_i == PfOnMiss && !found_q));

  always_comb begin
    for (int j = 0; j < MaxW; j++) begin
      in_set[j] = ((LaneW'(j) ^ off) >> wl_q) == '0;
    end
  end

  // victim: lowest lane holding the largest rank of the set
  always_comb begin
    for (int j = 0; j < MaxW; j++) begin
      hit_vec[j] = in_set[j] && rd_valid_q[j] && (rd_tag_q[j] == blk_q);
      inv_vec[j] = in_set[j] && !rd_valid_q[j];
      vic_vec[j] = in_set[j];
      for (int k = 0; k < MaxW; k++) begin
        if (in_set[k] && k < j && rd_rank_q[j] <= rd_rank_q[k]) vic_vec[j] = 1'b0;
        if (in_set[k] && k > j && rd_rank_q[j] < rd_rank_q[k]) vic_vec[j] = 1'b0;
      end
    end
  end

  always_comb begin
    any_hit  = |hit_vec;
    any_inv  = |inv_vec;
    hit_lane = '0;
    inv_lane = '0;
    vic_lane = '0;
    for (int j = MaxW - 1; j >= 0; j--) begin
      if (hit_vec[j]) hit_lane = LaneW'(j);
      if (inv_vec[j]) inv_lane = LaneW'(j);
      if (vic_vec[j]) vic_lane = LaneW'(j);
    end
  end

  always_comb begin
    tgt_lane  = found_q ? hit_lane_q : (inv_found_q ? inv_lane_q : vic_lane_q);
    prev_rank = rd_rank_q[tgt_lane];
    wr_tag    = rd_tag_q;
    wr_valid  = rd_valid_q;
    wr_rank   = rd_rank_q;
    if (found_q || alloc_q) begin
      for (int j = 0; j < MaxW; j++) begin
        if (in_set[j]) begin
          if (LaneW'(j) == tgt_lane) begin
            wr_rank[j] = '0;
          end else if (!found_q && inv_found_q) begin
            if (rd_rank_q[j] < RankLimit) wr_rank[j] = rd_rank_q[j] + RankW'(1);
          end else if (rd_rank_q[j] < prev_rank) begin
            wr_rank[j] = rd_rank_q[j] + RankW'(1);
          end
        end
      end
      if (!found_q) begin
        wr_tag[tgt_lane]   = blk_q;
        wr_valid[tgt_lane] = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == RowW'(Rows - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (req_valid_i) state_d = ST_READ;
      ST_READ:  state_d = ST_CMP;
      ST_CMP:   state_d = ST_WRITE;
      ST_WRITE: state_d = pf_go ? ST_READ : ST_OUT;
      ST_OUT:   if (m_axis_tready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    req_ready_o   = 1'b0;
    m_axis_tvalid = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_clr       = 1'b0;
    unique case (state_q)
      ST_CLEAR: mem_clr = 1'b1;
      ST_IDLE:  req_ready_o = 1'b1;
      ST_READ:  rd_en = 1'b1;
      ST_CMP:   ;
      ST_WRITE: mem_we = 1'b1;
      ST_OUT:   m_axis_tvalid = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_clr) begin
      tag_mem[clr_q]   <= '0;
      valid_mem[clr_q] <= '0;
      rank_mem[clr_q]  <= '0;
    end else if (mem_we) begin
      tag_mem[row]   <= wr_tag;
      valid_mem[row] <= wr_valid;
      rank_mem[row]  <= wr_rank;
    end
    if (rd_en) begin
      rd_tag_q   <= tag_mem[row];
      rd_valid_q <= valid_mem[row];
      rd_rank_q  <= rank_mem[row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      blk_q       <= '0;
      wl_q        <= '0;
      alloc_q     <= 1'b0;
      dmd_q       <= 1'b0;
      found_q     <= 1'b0;
      inv_found_q <= 1'b0;
      hit_lane_q  <= '0;
      inv_lane_q  <= '0;
      vic_lane_q  <= '0;
      hit_q       <= 1'b0;
      hits_q      <= '0;
      acc_q       <= '0;
    end else begin
      state_q <= state_d;
      if (mem_clr) clr_q <= clr_q + RowW'(1);
      if (req_valid_i && req_ready_o) begin
        blk_q   <= req_i.address[AddrW-1:OffW];
        wl_q    <= (assoc_log2_i > 3'(LaneW)) ? 3'(LaneW) : assoc_log2_i;
        alloc_q <= !req_i.mode || write_allocate_i;
        dmd_q   <= 1'b1;
      end
      if (state_q == ST_CMP) begin
        found_q     <= any_hit;
        inv_found_q <= any_inv;
        hit_lane_q  <= hit_lane;
        inv_lane_q  <= inv_lane;
        vic_lane_q  <= vic_lane;
      end
      if (state_q == ST_WRITE && dmd_q) begin
        hit_q <= found_q;
        if (found_q && hits_q != '1) hits_q <= hits_q + CntW'(1);
        if (acc_q != '1) acc_q <= acc_q + CntW'(1);
        dmd_q <= 1'b0;
        if (pf_go) begin
          blk_q   <= blk_q + BlkW'(1);
          alloc_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/salc_checker.sv -----
// port level checks for the cache model
// binds to set_assoc_lru_cache_sim_core
module salc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("beat changed");
  a_hits_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[32:1] <= m_axis_tdata[64:33]) else $error("hits > acc");
  a_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] && m_axis_tdata[64:33] == 32'd1
      |-> m_axis_tdata[32:1] == 32'd0) else $error("miss counted");
endmodule

bind set_assoc_lru_cache_sim_core salc_checker u_chk (.*);
